[hdl/assert_macros.svh]
// Assertion helpers for the heap block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define IMH_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define IMH_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

[hdl/imh_pkg.sv]
// ----------------------------------------------------------------------------
// imh_pkg
// Shared constants and types for the indexed min-heap.
// ----------------------------------------------------------------------------
package imh_pkg;
  localparam int CAPACITY    = 1024;
  localparam int MAX_HANDLES = 1024;
  localparam int VALUE_WIDTH = 32;
  localparam int PW = $clog2(CAPACITY);     // position index width
  localparam int HW = $clog2(MAX_HANDLES);  // handle index width
  localparam int CW = $clog2(CAPACITY + 1); // count width
  localparam int NW = $clog2(MAX_HANDLES + 2); // next handle width

  localparam logic [2:0] FN_QUERY  = 3'd0;
  localparam logic [2:0] FN_INSERT = 3'd1;
  localparam logic [2:0] FN_POP    = 3'd2;
  localparam logic [2:0] FN_DELETE = 3'd3;
  localparam logic [2:0] FN_CHANGE = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_BADH  = 2'd3;

  // heap entry: value and owning handle (handle minus one)
  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] val;
    logic [HW-1:0]                 hdl;
  } entry_t;

  localparam int EW = VALUE_WIDTH + HW;
endpackage

[hdl/indexed_min_heap.sv]
// ----------------------------------------------------------------------------
// indexed_min_heap
// Indexed binary min-heap with handle lookup, heap in RAM.
// ----------------------------------------------------------------------------
// Usage:
//  A request on the in_ channel (in_func, in_handle, in_value) runs one heap
//  operation: query, insert, pop minimum, delete by handle, change by handle.
//  Each request gives one result on the out_ channel: minimum, count, empty
//  flag, the handle issued by an insert and a status code.
//  One request is worked at a time. The heap lives in a RAM of entries
//  (value and handle) and a RAM of handle slots (live flag and position),
//  both with registered reads. A handle is only looked at below the next
//  handle, so slots never written are never trusted and need no clearing.
//  The work is a sift loop: an insert sifts up; pop, delete and change sift
//  down and, if the entry did not move, up. Each level is read, compared and
//  its swap written back through the single write port of each RAM.
//  in_stall is high whenever the engine is not idle.
//  The result register holds until out_stall falls; the next request is taken
//  as soon as the result has been loaded, so it overlaps the wait.
//  After reset the heap is empty, the next handle is one and no handle is
//  live; no clearing pass is run.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module indexed_min_heap (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [2:0]                           in_func,
  input  logic [10:0]                          in_handle,
  input  logic signed [31:0]                   in_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [31:0]                   out_min_value,
  output logic [10:0]                          out_count,
  output logic                                 out_heap_empty,
  output logic [10:0]                          out_new_handle,
  output logic [1:0]                           out_status
);
  localparam int PW = imh_pkg::PW;
  localparam int HW = imh_pkg::HW;
  localparam int CW = imh_pkg::CW;
  localparam int NW = imh_pkg::NW;
  localparam int VW = imh_pkg::VALUE_WIDTH;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_HPOS  = 11'b00000000010, // handle slot read issued
    S_RMLST = 11'b00000000100, // read last entry for removal
    S_RMWR  = 11'b00000001000, // write last into hole
    S_DRD   = 11'b00000010000, // sift down: left child in, read right child
    S_DCMP  = 11'b00000100000, // sift down: compare
    S_URD   = 11'b00001000000, // sift up: read parent
    S_UCMP  = 11'b00010000000, // sift up: compare
    S_SWP   = 11'b00100000000, // write second half of swap
    S_DONE  = 11'b01000000000, // read root for result
    S_RES   = 11'b10000000000  // load result
  } state_t;

  state_t state_r, state_nxt;

  // entry RAM
  logic              e_we;
  logic [PW-1:0]     e_wa, e_ra;
  imh_pkg::entry_t   e_wd, e_rd;
  // handle slot RAM: {live, position}
  logic              h_we;
  logic [HW-1:0]     h_wa, h_ra;
  logic [PW:0]       h_wd, h_rd;

  imh_ram #(.WIDTH(imh_pkg::EW), .DEPTH(imh_pkg::CAPACITY)) u_entries (
    .clk(clk), .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(e_ra), .rdata(e_rd));
  imh_ram #(.WIDTH(PW+1), .DEPTH(imh_pkg::MAX_HANDLES)) u_hpos (
    .clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd));

  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [NW-1:0]   nh_r, nh_nxt;
  logic [2:0]      fn_r, fn_nxt;
  logic [PW-1:0]   pos_r, pos_nxt;     // position of the walking entry
  imh_pkg::entry_t cur_r, cur_nxt;     // the walking entry
  imh_pkg::entry_t lc_r, lc_nxt;       // left child
  imh_pkg::entry_t oth_r, oth_nxt;     // entry swapped with cur
  logic [PW-1:0]   oth_pos_r, oth_pos_nxt;
  logic            up_after_r, up_after_nxt; // sift up after sift down
  logic            swp_up_r, swp_up_nxt;
  logic [1:0]      st_r, st_nxt;
  logic [10:0]     given_r, given_nxt;

  logic            ov_r, ov_nxt;
  logic signed [31:0] omin_r, omin_nxt;
  logic [10:0]     ocnt_r, ocnt_nxt, onh_r, onh_nxt;
  logic            oemp_r, oemp_nxt;
  logic [1:0]      ost_r, ost_nxt;

  logic            acc;
  logic [HW-1:0]   hidx;
  logic            hvalid;             // handle was issued; live flag read next
  logic [CW:0]     lchild, rchild;
  logic [PW-1:0]   parent;

  assign in_stall = (state_r != S_IDLE);
  assign acc      = in_valid && !in_stall;
  assign hidx     = HW'(in_handle - 11'd1);
  assign hvalid   = (in_handle != 11'd0) && (in_handle < 11'(nh_r));
  assign lchild   = (CW+1)'({pos_r, 1'b1});
  assign rchild   = (CW+1)'({pos_r, 1'b1}) + (CW+1)'(1);
  assign parent   = PW'((pos_r - PW'(1)) >> 1);

  function automatic logic lt(imh_pkg::entry_t a, imh_pkg::entry_t b);
    lt = a.val < b.val;
  endfunction

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r; nh_nxt = nh_r; fn_nxt = fn_r;
    pos_nxt = pos_r; cur_nxt = cur_r; lc_nxt = lc_r; oth_nxt = oth_r;
    oth_pos_nxt = oth_pos_r; up_after_nxt = up_after_r; swp_up_nxt = swp_up_r;
    st_nxt = st_r; given_nxt = given_r;
    ov_nxt = ov_r && out_stall;
    omin_nxt = omin_r; ocnt_nxt = ocnt_r; onh_nxt = onh_r; oemp_nxt = oemp_r;
    ost_nxt = ost_r;
    e_we = 1'b0; e_wa = '0; e_wd = cur_r; e_ra = '0;
    h_we = 1'b0; h_wa = '0; h_wd = '0; h_ra = hidx;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          fn_nxt = in_func; st_nxt = imh_pkg::ST_OK; given_nxt = '0;
          up_after_nxt = 1'b0;
          case (in_func)
            imh_pkg::FN_INSERT: begin
              if (cnt_r >= CW'(imh_pkg::CAPACITY) ||
                  nh_r > NW'(imh_pkg::MAX_HANDLES)) begin
                st_nxt = imh_pkg::ST_FULL; state_nxt = S_DONE;
              end else begin
                cur_nxt.val = VW'(in_value);
                cur_nxt.hdl = HW'(nh_r - NW'(1));
                pos_nxt = PW'(cnt_r);
                e_we = 1'b1; e_wa = PW'(cnt_r);
                e_wd.val = VW'(in_value); e_wd.hdl = HW'(nh_r - NW'(1));
                h_we = 1'b1; h_wa = HW'(nh_r - NW'(1)); h_wd = {1'b1, PW'(cnt_r)};
                given_nxt = 11'(nh_r);
                cnt_nxt = cnt_r + CW'(1); nh_nxt = nh_r + NW'(1);
                state_nxt = (cnt_r == '0) ? S_DONE : S_URD;
              end
            end
            imh_pkg::FN_POP: begin
              if (cnt_r == '0) begin
                st_nxt = imh_pkg::ST_EMPTY; state_nxt = S_DONE;
              end else begin
                pos_nxt = '0; e_ra = '0; state_nxt = S_RMLST;
              end
            end
            imh_pkg::FN_DELETE, imh_pkg::FN_CHANGE: begin
              if (!hvalid) begin
                st_nxt = imh_pkg::ST_BADH; state_nxt = S_DONE;
              end else begin
                cur_nxt.val = VW'(in_value); cur_nxt.hdl = hidx;
                state_nxt = S_HPOS;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_HPOS: begin
        pos_nxt = h_rd[PW-1:0];
        if (!h_rd[PW]) begin
          // issued but already popped or deleted
          st_nxt = imh_pkg::ST_BADH; state_nxt = S_DONE;
        end else if (fn_r == imh_pkg::FN_CHANGE) begin
          e_we = 1'b1; e_wa = h_rd[PW-1:0]; e_wd = cur_r;
          up_after_nxt = 1'b1; e_ra = PW'({h_rd[PW-1:0], 1'b1});
          state_nxt = S_DRD;
        end else begin
          state_nxt = S_RMLST;
        end
      end
      S_RMLST: begin
        // entry at pos is removed: kill its handle, read the last entry
        h_we = 1'b1; h_wd = {1'b0, pos_r};
        if (fn_r == imh_pkg::FN_POP) begin
          h_wa = e_rd.hdl;
        end else begin
          h_wa = cur_r.hdl;
        end
        e_ra = PW'(cnt_r - CW'(1));
        cnt_nxt = cnt_r - CW'(1);
        state_nxt = (CW'(pos_r) == cnt_r - CW'(1)) ? S_DONE : S_RMWR;
      end
      S_RMWR: begin
        cur_nxt = e_rd;
        e_we = 1'b1; e_wa = pos_r; e_wd = e_rd;
        h_we = 1'b1; h_wa = e_rd.hdl; h_wd = {1'b1, pos_r};
        up_after_nxt = 1'b1; e_ra = PW'({pos_r, 1'b1});
        state_nxt = S_DRD;
      end
      S_DRD: begin
        // left child read was issued
        if (lchild >= (CW+1)'(cnt_r)) begin
          state_nxt = up_after_r ? S_URD : S_DONE;
        end else begin
          lc_nxt = e_rd;
          e_ra = PW'(rchild);
          state_nxt = S_DCMP;
        end
      end
      S_DCMP: begin
        oth_nxt = lc_r; oth_pos_nxt = PW'(lchild);
        if (rchild < (CW+1)'(cnt_r) && lt(e_rd, lc_r)) begin
          oth_nxt = e_rd; oth_pos_nxt = PW'(rchild);
        end
        if (lt(oth_nxt, cur_r)) begin
          // child moves up into pos, cur goes to child slot
          e_we = 1'b1; e_wa = pos_r; e_wd = oth_nxt;
          h_we = 1'b1; h_wa = oth_nxt.hdl; h_wd = {1'b1, pos_r};
          swp_up_nxt = 1'b0; state_nxt = S_SWP;
        end else begin
          state_nxt = up_after_r ? S_URD : S_DONE;
        end
      end
      S_URD: begin
        if (pos_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          e_ra = parent; state_nxt = S_UCMP;
        end
      end
      S_UCMP: begin
        if (lt(cur_r, e_rd)) begin
          oth_nxt = e_rd; oth_pos_nxt = parent;
          e_we = 1'b1; e_wa = pos_r; e_wd = e_rd;
          h_we = 1'b1; h_wa = e_rd.hdl; h_wd = {1'b1, pos_r};
          swp_up_nxt = 1'b1; state_nxt = S_SWP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SWP: begin
        e_we = 1'b1; e_wa = oth_pos_r; e_wd = cur_r;
        h_we = 1'b1; h_wa = cur_r.hdl; h_wd = {1'b1, oth_pos_r};
        pos_nxt = oth_pos_r;
        if (swp_up_r) begin
          state_nxt = S_URD;
        end else begin
          // once moved down, the entry cannot need to climb
          up_after_nxt = 1'b0;
          e_ra = PW'({oth_pos_r, 1'b1});
          state_nxt = S_DRD;
        end
      end
      S_DONE: begin
        e_ra = '0; state_nxt = S_RES;
      end
      S_RES: begin
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1;
          omin_nxt = (cnt_r != '0) ? 32'(e_rd.val) : 32'sd0;
          ocnt_nxt = 11'(cnt_r); oemp_nxt = (cnt_r == '0);
          onh_nxt = given_r; ost_nxt = st_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; cnt_r <= '0; nh_r <= NW'(1); ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt;
      nh_r <= nh_nxt; ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fn_r <= fn_nxt; pos_r <= pos_nxt; cur_r <= cur_nxt; lc_r <= lc_nxt;
    oth_r <= oth_nxt; oth_pos_r <= oth_pos_nxt; up_after_r <= up_after_nxt;
    swp_up_r <= swp_up_nxt; st_r <= st_nxt; given_r <= given_nxt;
    omin_r <= omin_nxt; ocnt_r <= ocnt_nxt; onh_r <= onh_nxt;
    oemp_r <= oemp_nxt; ost_r <= ost_nxt;
  end

  assign out_valid      = ov_r;
  assign out_min_value  = omin_r;
  assign out_count      = ocnt_r;
  assign out_heap_empty = oemp_r;
  assign out_new_handle = onh_r;
  assign out_status     = ost_r;

  `IMH_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, cnt_r <= CW'(imh_pkg::CAPACITY),
    "count above capacity")
  `IMH_ASSERT_IMP(a_empty_min, clk, rst_n, out_valid && out_heap_empty,
    out_min_value == 32'sd0 && out_count == 11'd0, "empty result not clean")
  `IMH_ASSERT_NXT(a_no_accept_busy, clk, rst_n, acc, state_r != S_IDLE,
    "engine idle after accepting a request")
  `IMH_ASSERT_IMP(a_handle_ok, clk, rst_n, out_valid && out_new_handle != 11'd0,
    out_status == imh_pkg::ST_OK, "handle issued with error status")
endmodule

[hdl/imh_ram.sv]
// ----------------------------------------------------------------------------
// imh_ram
// Single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module imh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
